// File: src/nls_pkg.sv
// package for the natural log series unit: widths, constants and channel payload types
// no dependencies
`timescale 1ns / 1ps

package nls_pkg;
    localparam int unsigned XW         = 32;
    localparam int unsigned LNW        = 29;
    localparam int unsigned TERMW      = 17;
    localparam int unsigned FRAC       = 30;
    localparam int unsigned MAX_TERMS_DEF = 65536;
    localparam logic [TERMW-1:0] TERM_RESET = 17'd65536;
    localparam logic [32:0] ONE_Q16    = 33'd65536;
    localparam logic [LNW-1:0] OUT_POS_MAX = 29'h0FFF_FFFF;
    localparam logic [LNW-1:0] OUT_NEG_MIN = 29'h1000_0000;

    typedef struct packed {
        logic [XW-1:0] x_value;
    } t_in;

    typedef struct packed {
        logic signed [LNW-1:0] ln_value;
        logic                  invalid;
    } t_out;
endpackage

// File: src/nls_if.sv
// valid/ready channel interfaces for the natural log series unit
// depends on nls_pkg
`timescale 1ns / 1ps

interface nls_in_if import nls_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nls_out_if import nls_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nls_cfg_if import nls_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TERMW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/natural_log_series_unit.sv
// natural log series unit: ln(x) by the atanh series on one shared divider and multiplier
// depends on nls_pkg and the channel interfaces in nls_if
// per input: a 64-step restoring divide gives y, one 32x32 multiply gives y squared; then per term
// a 64-step restoring divide, one 32x32 multiply and a shift; a rounding and saturation state finishes
// loop stops early once the power is 0; zero input: result valid in the cycle after it is taken
// one item at a time; sync active-low reset: count 65536, idle
`timescale 1ns / 1ps

module natural_log_series_unit import nls_pkg::*; #(
    parameter int unsigned MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nls_in_if.sink    in_ch,
    nls_out_if.source out_ch,
    nls_cfg_if.sink   cfg_ch
);
    localparam int unsigned CW = $clog2(MAX_TERMS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_YDIV, S_Y2, S_TDIV, S_MLO, S_MHI, S_NEXT, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic [TERMW-1:0] r_term_count;
    logic [CW-1:0]    r_terms, r_i;
    logic             r_neg;
    logic [31:0]      r_y2;
    logic [31:0]      r_p;        // power magnitude, stays below 2^30
    logic [63:0]      r_acc;
    // shared restoring divider: quotient in r_q, remainder r_rem
    logic [63:0]      r_q;
    logic [33:0]      r_dvs;
    logic [33:0]      r_rem;
    logic [6:0]       r_cnt;
    logic [63:0]      r_prod;
    t_out             r_out;

    logic [34:0] w_trial;
    logic [34:0] w_shift;
    logic [63:0] w_mul;
    logic [31:0] w_ma, w_mb;
    logic [32:0] w_x;
    logic [32:0] w_num;
    logic [63:0] w_mag;
    logic [CW-1:0] w_lim;

    assign w_shift = {r_rem, r_q[63]};
    assign w_trial = w_shift - {1'b0, r_dvs};
    // one 32x32 multiplier shared by y squared and the power update
    assign w_mul   = {32'd0, w_ma} * {32'd0, w_mb};
    assign w_x     = {1'b0, in_ch.data.x_value};
    assign w_num   = (w_x < ONE_Q16) ? (ONE_Q16 - w_x) : (w_x - ONE_Q16);
    assign w_mag   = (r_acc + 64'd16) >> 5;
    assign w_lim   = ({15'd0, r_term_count} > 32'(MAX_TERMS)) ? CW'(MAX_TERMS)
                                                               : CW'(r_term_count);

    always_comb begin
        case (r_state)
            S_Y2:    begin w_ma = r_q[31:0]; w_mb = r_q[31:0]; end
            S_MLO:   begin w_ma = r_p;       w_mb = r_y2;      end
            default: begin w_ma = r_p;       w_mb = r_y2;      end
        endcase
    end

    assign in_ch.ready  = (r_state == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term_count <= TERM_RESET;
        end else begin
            if (cfg_ch.valid) r_term_count <= cfg_ch.data;
            case (r_state)
                S_IDLE: if (in_ch.valid) begin
                    r_neg   <= (w_x < ONE_Q16);
                    r_terms <= w_lim;
                    r_i     <= '0;
                    r_acc   <= '0;
                    if (in_ch.data.x_value == '0) begin
                        r_out   <= '{ln_value: '0, invalid: 1'b1};
                        r_state <= S_OUT;
                    end else begin
                        // dividend num << 30 in 64-bit quotient register
                        r_q     <= {w_num[31:0], 30'd0, 2'd0} >> 2;
                        r_dvs   <= {1'b0, w_x + ONE_Q16};
                        r_rem   <= '0;
                        r_cnt   <= 7'd64;
                        r_state <= S_YDIV;
                    end
                end
                S_YDIV, S_TDIV: begin
                    if (r_cnt == 7'd0) begin
                        if (r_state == S_YDIV) begin
                            r_p     <= r_q[31:0];
                            r_state <= S_Y2;
                        end else begin
                            r_acc   <= r_acc + r_q;
                            r_state <= S_MLO;
                        end
                    end else begin
                        r_cnt <= r_cnt - 7'd1;
                        if (!w_trial[34]) begin
                            r_rem <= w_trial[33:0];
                            r_q   <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= w_shift[33:0];
                            r_q   <= {r_q[62:0], 1'b0};
                        end
                    end
                end
                S_Y2: begin
                    r_y2    <= 32'(w_mul >> FRAC);
                    r_state <= S_NEXT;
                end
                S_MLO: begin
                    r_prod  <= w_mul;
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_p     <= 32'(r_prod >> FRAC);
                    r_i     <= r_i + CW'(1);
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_i == r_terms || r_p == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_q     <= {32'd0, r_p};
                        r_dvs   <= 34'({r_i, 1'b1});
                        r_rem   <= '0;
                        r_cnt   <= 7'd64;
                        r_state <= S_TDIV;
                    end
                end
                S_FIN: begin
                    r_out.invalid <= 1'b0;
                    if (r_neg)
                        r_out.ln_value <= (w_mag > 64'(OUT_NEG_MIN)) ? OUT_NEG_MIN
                                        : LNW'(-w_mag);
                    else
                        r_out.ln_value <= (w_mag > 64'(OUT_POS_MAX)) ? OUT_POS_MAX
                                        : LNW'(w_mag);
                    r_state <= S_OUT;
                end
                S_OUT: if (out_ch.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready) else $error("input ready while busy");
    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.data.invalid) |-> (out_ch.data.ln_value == '0))
        else $error("invalid result not zero");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
        else $error("result dropped");
    a_terms_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> (r_i <= r_terms)) else $error("term index overrun");
endmodule

// File: tb/natural_log_series_unit_tb.sv
// testbench for natural_log_series_unit: directed table then randomized phases per term count
// depends on nls_pkg, nls_if and the unit itself; results are checked against a local predictor or typed table results
`timescale 1ns / 1ps

module natural_log_series_unit_tb;
    import nls_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    typedef enum logic {ROW_CFG, ROW_ARG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [31:0] value;
        bit          typed;
        t_out        res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    nls_in_if  in_ch ();
    nls_out_if out_ch ();
    nls_cfg_if cfg_ch ();

    natural_log_series_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    logic [TERMW-1:0] term_reg;
    t_out             ln_expected[$];
    int unsigned      err_count;
    int unsigned      hold_cycles;
    bit               no_idle;
    int unsigned      cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // atanh series on magnitudes, sign applied at the end
    function automatic t_out predict_ln(input logic [31:0] x, input logic [TERMW-1:0] terms_in);
        logic [63:0] num, den, ymag, y2, p, acc, mag;
        logic [31:0] terms, i;
        bit          neg;
        t_out        r;
        r.invalid  = 1'b0;
        r.ln_value = '0;
        if (x == 32'd0) begin
            r.invalid = 1'b1;
            return r;
        end
        neg  = x < 32'd65536;
        num  = neg ? (64'd65536 - x) : (64'(x) - 64'd65536);
        den  = 64'(x) + 64'd65536;
        ymag = (num << FRAC) / den;
        terms = terms_in;
        if (terms > MAX_TERMS_DEF)
            terms = MAX_TERMS_DEF;
        y2  = (ymag * ymag) >> FRAC;
        p   = ymag;
        acc = '0;
        for (i = 0; i < terms; i++) begin
            if (p == 0)
                break;
            acc += p / (2 * 64'(i) + 1);
            p = (p * y2) >> FRAC;
        end
        mag = (acc + 16) >> 5;
        if (neg) begin
            if (mag > 64'(OUT_NEG_MIN))
                mag = 64'(OUT_NEG_MIN);
            r.ln_value = LNW'(64'd0 - mag);
        end else begin
            if (mag > 64'(OUT_POS_MAX))
                mag = 64'(OUT_POS_MAX);
            r.ln_value = LNW'(mag);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("natural_log_series_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stalls, a counted long hold-off, or always ready when no_idle is set
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = no_idle ? 1'b1 : ($urandom_range(99) >= 29);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (ln_expected.size() == 0) begin
                report_mismatch("unexpected beat", 32'(out_ch.data), 32'd0);
            end else begin
                t_out want;
                want = ln_expected.pop_front();
                if (out_ch.data.ln_value !== want.ln_value)
                    report_mismatch("ln_value", 32'(out_ch.data.ln_value), 32'(want.ln_value));
                if (out_ch.data.invalid !== want.invalid)
                    report_mismatch("invalid", 32'(out_ch.data.invalid), 32'(want.invalid));
            end
        end
    end

    task automatic send_arg(input logic [31:0] x, input bit typed, input t_out res);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 29) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.data.x_value = x;
        do @(posedge i_clk); while (!in_ch.ready);
        ln_expected.push_back(typed ? res : predict_ln(x, term_reg));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (ln_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // only called with the unit idle
    task automatic write_terms(input logic [TERMW-1:0] n);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = n;
        do @(posedge i_clk); while (!cfg_ch.ready);
        term_reg = n;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] random_arg();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return $urandom;
        else if (pick < 60)
            return 32'd65536 + $urandom_range(4096) - 32'd2048;
        else if (pick < 80)
            return $urandom_range(65535, 1);
        else if (pick < 88)
            return 32'd0;
        else
            return {1'b1, 31'($urandom)};
    endfunction

    t_row directed[] = '{
        '{ROW_ARG, 32'd0,          1'b1, '{ln_value: '0, invalid: 1'b1}},
        '{ROW_ARG, 32'd65536,      1'b1, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd65537,      1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd65535,      1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_CFG, 32'd0,          1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'hFFFF_FFFF,  1'b1, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd1,          1'b1, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd0,          1'b1, '{ln_value: '0, invalid: 1'b1}},
        '{ROW_CFG, 32'd1,          1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'hFFFF_FFFF,  1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd1,          1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd131072,     1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd32768,      1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_CFG, 32'd131071,     1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd65536,      1'b1, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd65600,      1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd65472,      1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_CFG, 32'd65536,      1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'd65540,      1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_CFG, 32'd12,         1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'h8000_0000,  1'b0, '{ln_value: '0, invalid: 1'b0}},
        '{ROW_ARG, 32'h7FFF_FFFF,  1'b0, '{ln_value: '0, invalid: 1'b0}}
    };

    logic [TERMW-1:0] phase_terms[6] = '{17'd1, 17'd2, 17'd7, 17'd16, 17'd5, 17'd300};

    initial begin
        t_out none;
        int   count;
        none         = '{ln_value: '0, invalid: 1'b0};
        err_count    = 0;
        hold_cycles  = 0;
        no_idle      = 1'b0;
        term_reg     = TERM_RESET;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_CFG) begin
                drain_results();
                write_terms(TERMW'(directed[k].value));
            end else begin
                send_arg(directed[k].value, directed[k].typed, directed[k].res);
            end
        end
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            write_terms(ph == 4 ? TERMW'($urandom_range(12, 1)) : phase_terms[ph]);
            // receiver blocked while inputs keep coming, so the unit backs up
            if (ph == 1)
                hold_cycles = 2000;
            no_idle = (ph == 3);
            count = (ph == 5) ? 8 : 18;
            for (int n = 0; n < count; n++)
                send_arg(ph == 5 && n < 4 ? random_arg() & 32'h0003_FFFF : random_arg(),
                         1'b0, none);
            drain_results();
        end

        repeat (200) @(posedge i_clk);
        if (err_count == 0) begin
            $display("natural_log_series_unit_tb: PASS");
        end else begin
            $display("natural_log_series_unit_tb: FAIL");
        end
        $finish;
    end
endmodule
